// ===== src/prcd_pkg.sv =====
// Package for the pixel row code decoder.
// Holds the shared sizes, the sample class and register codes and the result type.
// Used by every module of the block; it depends on nothing.
`timescale 1ns / 1ps

package prcd_pkg;

  localparam int SAMPLES  = 32;
  localparam int IDX_W    = $clog2(SAMPLES);
  localparam int LEVEL_W  = 8;
  localparam int PREFIX_W = 28;
  localparam int VALUE_W  = PREFIX_W + 1;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [LEVEL_W-1:0] HIGH_THR_RESET = LEVEL_W'(200);
  localparam logic [LEVEL_W-1:0] LOW_THR_RESET  = LEVEL_W'(55);

  typedef enum logic [1:0] {
    CLS_DARK   = 2'd0,
    CLS_BRIGHT = 2'd1,
    CLS_MID    = 2'd2
  } cls_e;

  typedef enum logic [0:0] {
    REG_HIGH_THR = 1'b0,
    REG_LOW_THR  = 1'b1
  } reg_e;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      found;
  } res_t;

endpackage

// ===== src/prcd_classify.sv =====
// Sample classifier of the pixel row code decoder.
// Sorts one grey level into bright, dark or mid against the two thresholds.
// Depends on prcd_pkg.
`timescale 1ns / 1ps

module prcd_classify (
  input  logic [prcd_pkg::LEVEL_W-1:0] level_i,
  input  logic [prcd_pkg::LEVEL_W-1:0] high_thr_i,
  input  logic [prcd_pkg::LEVEL_W-1:0] low_thr_i,
  output prcd_pkg::cls_e               cls_o
);

  always_comb begin
    if (level_i > high_thr_i) begin
      cls_o = prcd_pkg::CLS_BRIGHT;
    end else if (level_i < low_thr_i) begin
      cls_o = prcd_pkg::CLS_DARK;
    end else begin
      cls_o = prcd_pkg::CLS_MID;
    end
  end

endmodule

// ===== src/prcd_group.sv =====
// Group tracker of the pixel row code decoder.
// Keeps the running prefix, its three-deep history and the end marker test over a group.
// Depends on prcd_pkg.
`timescale 1ns / 1ps

module prcd_group (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  prcd_pkg::cls_e cls_i,
  output logic           last_o,
  output prcd_pkg::res_t res_o
);

  logic [prcd_pkg::IDX_W-1:0]    idx_q, idx_d;
  logic [3:0]                    recent_q, recent_d;
  logic [prcd_pkg::PREFIX_W-1:0] hist_q [3];
  logic [prcd_pkg::PREFIX_W-1:0] hist_d [3];
  logic                          open_q, open_d;
  prcd_pkg::cls_e                lead_q, lead_d;
  logic [prcd_pkg::VALUE_W-1:0]  held_value_q, held_value_d;
  logic                          held_found_q, held_found_d;

  prcd_pkg::cls_e                lead;
  logic                          marker;
  logic [prcd_pkg::VALUE_W-1:0]  mag_ext;
  logic [prcd_pkg::VALUE_W-1:0]  value;
  logic [prcd_pkg::PREFIX_W-1:0] prefix;

  assign last_o = (idx_q == prcd_pkg::IDX_W'(prcd_pkg::SAMPLES - 1));

  always_comb begin
    lead    = (idx_q == '0) ? cls_i : lead_q;
    marker  = (idx_q >= prcd_pkg::IDX_W'(2)) &&
              (idx_q <= prcd_pkg::IDX_W'(prcd_pkg::SAMPLES - 2)) &&
              (cls_i == prcd_pkg::CLS_DARK) &&
              (recent_q[1:0] == prcd_pkg::CLS_BRIGHT) &&
              (recent_q[3:2] == prcd_pkg::CLS_DARK);
    mag_ext = {1'b0, hist_q[2]};
    value   = (lead == prcd_pkg::CLS_DARK) ? (prcd_pkg::VALUE_W'(0) - mag_ext) : mag_ext;

    prefix = hist_q[0];
    open_d = open_q;
    if (open_q) begin
      if (cls_i == prcd_pkg::CLS_MID) begin
        open_d = 1'b0;
      end else begin
        prefix = {hist_q[0][prcd_pkg::PREFIX_W-2:0], cls_i[0]};
      end
    end

    held_value_d = marker ? value : held_value_q;
    held_found_d = marker | held_found_q;
    res_o.value  = $signed(held_value_d);
    res_o.found  = held_found_d;

    lead_d    = lead;
    hist_d[0] = prefix;
    hist_d[1] = hist_q[0];
    hist_d[2] = hist_q[1];
    recent_d  = {recent_q[1:0], cls_i};
    idx_d     = idx_q + prcd_pkg::IDX_W'(1);

    if (last_o) begin
      idx_d        = '0;
      recent_d     = '0;
      hist_d[0]    = '0;
      hist_d[1]    = '0;
      hist_d[2]    = '0;
      open_d       = 1'b1;
      lead_d       = prcd_pkg::CLS_MID;
      held_value_d = '0;
      held_found_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      recent_q     <= '0;
      hist_q[0]    <= '0;
      hist_q[1]    <= '0;
      hist_q[2]    <= '0;
      open_q       <= 1'b1;
      lead_q       <= prcd_pkg::CLS_MID;
      held_value_q <= '0;
      held_found_q <= 1'b0;
    end else if (step_i) begin
      idx_q        <= idx_d;
      recent_q     <= recent_d;
      hist_q[0]    <= hist_d[0];
      hist_q[1]    <= hist_d[1];
      hist_q[2]    <= hist_d[2];
      open_q       <= open_d;
      lead_q       <= lead_d;
      held_value_q <= held_value_d;
      held_found_q <= held_found_d;
    end
  end

endmodule

// ===== src/pixel_row_code_decoder.sv =====
// A group's result word is valid once its last sample passes the input and output registers.
// Throughput: one sample word per cycle if not stalled; one result word per group of SAMPLES.
// A sample stalls only while a finished result waits and the next group result is due.
// Reset clears the group state and the output valid; thresholds return to 200 and 55.
// Top level of the pixel row code decoder: input register, config registers, output register.
// Depends on prcd_pkg, prcd_classify and prcd_group.
`timescale 1ns / 1ps

module pixel_row_code_decoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [prcd_pkg::ADDR_W-1:0]         paddr,
  input  logic [prcd_pkg::DATA_W-1:0]         pwdata,
  output logic [prcd_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [prcd_pkg::LEVEL_W-1:0]        pixel_level_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [prcd_pkg::VALUE_W-1:0] code_value_o,
  output logic                                marker_found_o
);

  logic [prcd_pkg::LEVEL_W-1:0] high_thr_q, low_thr_q;
  logic [prcd_pkg::LEVEL_W-1:0] pixel_q;
  logic                         s1_valid_q;
  logic                         out_valid_q;
  prcd_pkg::res_t               out_q;

  prcd_pkg::reg_e               reg_sel;
  logic                         cfg_wr;
  prcd_pkg::cls_e               cls;
  logic                         last;
  prcd_pkg::res_t               res;
  logic                         hold;
  logic                         step;
  logic                         in_accept;

  assign pready  = 1'b1;
  assign reg_sel = prcd_pkg::reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_sel)
      prcd_pkg::REG_HIGH_THR: prdata = prcd_pkg::DATA_W'(high_thr_q);
      prcd_pkg::REG_LOW_THR:  prdata = prcd_pkg::DATA_W'(low_thr_q);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_thr_q <= prcd_pkg::HIGH_THR_RESET;
      low_thr_q  <= prcd_pkg::LOW_THR_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        prcd_pkg::REG_HIGH_THR: high_thr_q <= pwdata[prcd_pkg::LEVEL_W-1:0];
        prcd_pkg::REG_LOW_THR:  low_thr_q  <= pwdata[prcd_pkg::LEVEL_W-1:0];
        default:                ;
      endcase
    end
  end

  assign hold       = s1_valid_q && last && out_valid_q && out_stall_i;
  assign step       = s1_valid_q && !hold;
  assign in_stall_o = hold;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (step) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pixel_q <= pixel_level_i;
    end
  end

  prcd_classify u_classify (
    .level_i    (pixel_q),
    .high_thr_i (high_thr_q),
    .low_thr_i  (low_thr_q),
    .cls_o      (cls)
  );

  prcd_group u_group (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cls_i  (cls),
    .last_o (last),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && last) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && last) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign code_value_o   = out_q.value;
  assign marker_found_o = out_q.found;

endmodule

// ===== src/prcd_checker.sv =====
// Port-level checker for the pixel row code decoder, bound to the top level.
// Depends on prcd_pkg and pixel_row_code_decoder.
`timescale 1ns / 1ps

module prcd_props (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [prcd_pkg::VALUE_W-1:0] code_value_o,
  input logic                                marker_found_o
);

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(code_value_o) &&
    $stable(marker_found_o))
    else $error("Stalled result word changed.");

  a_no_marker_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !marker_found_o |-> code_value_o == '0)
    else $error("Result word without marker carries a nonzero value.");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("Input stalled while no result word was blocked.");

  a_result_needs_sample : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("Result word produced without an accepted sample word.");

endmodule

bind pixel_row_code_decoder prcd_props u_prcd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .code_value_o   (code_value_o),
  .marker_found_o (marker_found_o)
);
